// ===== hdl/fsk_period_tone_detector_assert.svh =====
// assertion macros shared by the tone detector rtl
`ifndef FSK_PERIOD_TONE_DETECTOR_ASSERT_SVH
`define FSK_PERIOD_TONE_DETECTOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FPTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define FPTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/fsk_ptd_pkg.sv =====
package fsk_ptd_pkg;

  // field widths
  localparam int unsigned CAP_W   = 16;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 3;
  // signed difference: covers -65535 .. 131070 and the window bounds
  localparam int unsigned DIFF_W  = 19;

  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_CAPTURE  = 2'd0;
  localparam logic [OP_W-1:0] OP_OVERFLOW = 2'd1;
  localparam logic [OP_W-1:0] OP_READ     = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_MARK_CENTER  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SPACE_CENTER = 3'd1;
  localparam logic [IDX_W-1:0] REG_TOLERANCE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_MARK_LIMIT   = 3'd3;
  localparam logic [IDX_W-1:0] REG_SPACE_LIMIT  = 3'd4;
  localparam logic [IDX_W-1:0] REG_WRAP         = 3'd5;
  localparam logic [IDX_W-1:0] REG_MARK_FREQ    = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPACE_FREQ   = 3'd7;

  // register reset values
  localparam logic [VAL_W-1:0] RST_MARK_CENTER  = 16'd650;
  localparam logic [VAL_W-1:0] RST_SPACE_CENTER = 16'd325;
  localparam logic [VAL_W-1:0] RST_TOLERANCE    = 16'd100;
  localparam logic [CNT_W-1:0] RST_MARK_LIMIT   = 4'd2;
  localparam logic [CNT_W-1:0] RST_SPACE_LIMIT  = 4'd4;
  localparam logic [VAL_W-1:0] RST_WRAP         = 16'hFFFF;
  localparam logic [VAL_W-1:0] RST_MARK_FREQ    = 16'd1200;
  localparam logic [VAL_W-1:0] RST_SPACE_FREQ   = 16'd2400;

  typedef struct packed {
    logic [VAL_W-1:0] mark_center;
    logic [VAL_W-1:0] space_center;
    logic [VAL_W-1:0] window_tolerance;
    logic [CNT_W-1:0] mark_count_limit;
    logic [CNT_W-1:0] space_count_limit;
    logic [VAL_W-1:0] wrap_amount;
    logic [VAL_W-1:0] mark_frequency;
    logic [VAL_W-1:0] space_frequency;
  } cfg_t;

  // classifier verdict for one half-period
  typedef struct packed {
    logic             is_mark;
    logic             is_space;
    logic [VAL_W-1:0] period;
  } cls_t;

endpackage

// ===== hdl/fsk_period_tone_detector.sv =====
// channel | dir | tdata (low bit up)                 | tuser
// in_     | in  | capture_value[15:0]                | operation[1:0]
// out_    | out | frequency[15:0], half_period[31:16] | ready_res
// cfg_    | in  | write: cfg_index selects, cfg_wdata | -
//
// one item per clock while out_tready stays high; the result is registered after
// the input register (input register, then result register); the state update and
// window test sit between those two registers in a single pass
// in_tready drops only while both the input register and the result register
// are full and out_tready is low
// rst_n is synchronous; reset clears the detector state and loads register
// defaults
module fsk_period_tone_detector #(
  parameter int unsigned COUNT_WIDTH = fsk_ptd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // capture_value[15:0]
  input  logic [fsk_ptd_pkg::OP_W-1:0]  in_tuser,   // operation[1:0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // frequency, half_period
  output logic                          out_tuser,  // ready_res
  input  logic                          cfg_we,
  input  logic [fsk_ptd_pkg::IDX_W-1:0] cfg_index,
  input  logic [fsk_ptd_pkg::VAL_W-1:0] cfg_wdata
);

`include "fsk_period_tone_detector_assert.svh"

  // captures are kept at the timer width, never above the field width
  localparam int unsigned CapW = (COUNT_WIDTH < fsk_ptd_pkg::CAP_W) ?
                                 COUNT_WIDTH : fsk_ptd_pkg::CAP_W;
  localparam int unsigned VW = fsk_ptd_pkg::VAL_W;
  localparam int unsigned CW = fsk_ptd_pkg::CNT_W;

  fsk_ptd_pkg::cfg_t cfg;
  fsk_ptd_pkg::cls_t cls;

  logic                         s1_valid_r;
  logic [fsk_ptd_pkg::OP_W-1:0] s1_op_r;
  logic [CapW-1:0]              s1_cap_r;
  logic                         s1_adv;
  logic                         in_fire;

  logic            have_first_r, have_first_nxt;
  logic [CapW-1:0] last_cap_r, last_cap_nxt;
  logic [CW-1:0]   mark_count_r, mark_count_nxt;
  logic [CW-1:0]   space_count_r, space_count_nxt;
  logic [CW-1:0]   mark_inc, space_inc;
  logic            ready_r, ready_nxt;
  logic [VW-1:0]   pub_freq_r, pub_freq_nxt;
  logic [VW-1:0]   pub_period_r, pub_period_nxt;

  logic            out_valid_r;
  logic [VW-1:0]   out_freq_r;
  logic [VW-1:0]   out_period_r;
  logic            out_ready_res_r;

  fsk_ptd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fsk_ptd_classify #(
    .CAP_BITS (CapW)
  ) u_classify (
    .cap      (s1_cap_r),
    .last_cap (last_cap_r),
    .cfg      (cfg),
    .cls      (cls)
  );

  // handshake: stage 1 moves on when the result slot is free or draining
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r  <= in_tuser;
      s1_cap_r <= in_tdata[CapW-1:0];
    end
  end

  // counter steps, 4-bit wrap
  assign mark_inc  = mark_count_r + CW'(1);
  assign space_inc = space_count_r + CW'(1);

  // detector state update for the item in stage 1
  always_comb begin
    have_first_nxt  = have_first_r;
    last_cap_nxt    = last_cap_r;
    mark_count_nxt  = mark_count_r;
    space_count_nxt = space_count_r;
    ready_nxt       = ready_r;
    pub_freq_nxt    = pub_freq_r;
    pub_period_nxt  = pub_period_r;
    case (s1_op_r)
      fsk_ptd_pkg::OP_CAPTURE: begin
        last_cap_nxt = s1_cap_r;
        if (!have_first_r) begin
          have_first_nxt = 1'b1;
        end else if (cls.is_mark) begin
          if (mark_count_r == '0) begin
            ready_nxt      = 1'b1;
            pub_freq_nxt   = cfg.mark_frequency;
            pub_period_nxt = cls.period;
          end
          mark_count_nxt  = (mark_inc == cfg.mark_count_limit) ? '0 : mark_inc;
          space_count_nxt = '0;
        end else if (cls.is_space) begin
          if (space_count_r == '0) begin
            ready_nxt      = 1'b1;
            pub_freq_nxt   = cfg.space_frequency;
            pub_period_nxt = cls.period;
          end
          space_count_nxt = (space_inc == cfg.space_count_limit) ? '0 : space_inc;
          mark_count_nxt  = '0;
        end
      end
      fsk_ptd_pkg::OP_READ: begin
        ready_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_first_r  <= 1'b0;
      last_cap_r    <= '0;
      mark_count_r  <= '0;
      space_count_r <= '0;
      ready_r       <= 1'b0;
      pub_freq_r    <= '0;
      pub_period_r  <= '0;
    end else if (s1_adv) begin
      have_first_r  <= have_first_nxt;
      last_cap_r    <= last_cap_nxt;
      mark_count_r  <= mark_count_nxt;
      space_count_r <= space_count_nxt;
      ready_r       <= ready_nxt;
      pub_freq_r    <= pub_freq_nxt;
      pub_period_r  <= pub_period_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_freq_r      <= pub_freq_nxt;
      out_period_r    <= pub_period_nxt;
      out_ready_res_r <= ready_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_period_r, out_freq_r};
  assign out_tuser  = out_ready_res_r;

  // checks
  `FPTD_ASSERT_NOW(a_counts_exclusive, 1'b1,
                   (mark_count_r == '0) || (space_count_r == '0),
                   "mark and space counts both nonzero")
  `FPTD_ASSERT_NEXT(a_read_clears, s1_adv && (s1_op_r == fsk_ptd_pkg::OP_READ),
                    !out_ready_res_r, "read item left ready set")
  `FPTD_ASSERT_NEXT(a_pub_only_on_capture,
                    s1_adv && (s1_op_r != fsk_ptd_pkg::OP_CAPTURE),
                    $stable(pub_freq_r) && $stable(pub_period_r),
                    "publication changed without capture")
  `FPTD_ASSERT_NOW(a_ready_when_slot_free, !out_valid_r, in_tready,
                   "input stalled with empty result slot")

endmodule

// ===== hdl/fsk_ptd_cfg.sv =====
module fsk_ptd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fsk_ptd_pkg::IDX_W-1:0] cfg_index,
  input  logic [fsk_ptd_pkg::VAL_W-1:0] cfg_wdata,
  output fsk_ptd_pkg::cfg_t             cfg
);

  fsk_ptd_pkg::cfg_t cfg_r;

  // register file, written by index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mark_center       <= fsk_ptd_pkg::RST_MARK_CENTER;
      cfg_r.space_center      <= fsk_ptd_pkg::RST_SPACE_CENTER;
      cfg_r.window_tolerance  <= fsk_ptd_pkg::RST_TOLERANCE;
      cfg_r.mark_count_limit  <= fsk_ptd_pkg::RST_MARK_LIMIT;
      cfg_r.space_count_limit <= fsk_ptd_pkg::RST_SPACE_LIMIT;
      cfg_r.wrap_amount       <= fsk_ptd_pkg::RST_WRAP;
      cfg_r.mark_frequency    <= fsk_ptd_pkg::RST_MARK_FREQ;
      cfg_r.space_frequency   <= fsk_ptd_pkg::RST_SPACE_FREQ;
    end else if (cfg_we) begin
      case (cfg_index)
        fsk_ptd_pkg::REG_MARK_CENTER:  cfg_r.mark_center      <= cfg_wdata;
        fsk_ptd_pkg::REG_SPACE_CENTER: cfg_r.space_center     <= cfg_wdata;
        fsk_ptd_pkg::REG_TOLERANCE:    cfg_r.window_tolerance <= cfg_wdata;
        fsk_ptd_pkg::REG_MARK_LIMIT:
          cfg_r.mark_count_limit <= cfg_wdata[fsk_ptd_pkg::CNT_W-1:0];
        fsk_ptd_pkg::REG_SPACE_LIMIT:
          cfg_r.space_count_limit <= cfg_wdata[fsk_ptd_pkg::CNT_W-1:0];
        fsk_ptd_pkg::REG_WRAP:         cfg_r.wrap_amount      <= cfg_wdata;
        fsk_ptd_pkg::REG_MARK_FREQ:    cfg_r.mark_frequency   <= cfg_wdata;
        fsk_ptd_pkg::REG_SPACE_FREQ:   cfg_r.space_frequency  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/fsk_ptd_classify.sv =====
module fsk_ptd_classify #(
  parameter int unsigned CAP_BITS = 16
) (
  input  logic [CAP_BITS-1:0] cap,
  input  logic [CAP_BITS-1:0] last_cap,
  input  fsk_ptd_pkg::cfg_t   cfg,
  output fsk_ptd_pkg::cls_t   cls
);

  localparam int unsigned DW = fsk_ptd_pkg::DIFF_W;

  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] wrap_add;
  logic signed [DW-1:0] mark_lo;
  logic signed [DW-1:0] mark_hi;
  logic signed [DW-1:0] space_lo;
  logic signed [DW-1:0] space_hi;

  // half-period with wrap correction when the timer rolled over
  always_comb begin
    wrap_add = (cap < last_cap) ? DW'(cfg.wrap_amount) : '0;
    diff     = DW'(cap) - DW'(last_cap) + wrap_add;
  end

  // strict window bounds around each center
  always_comb begin
    mark_lo  = DW'(cfg.mark_center)  - DW'(cfg.window_tolerance);
    mark_hi  = DW'(cfg.mark_center)  + DW'(cfg.window_tolerance);
    space_lo = DW'(cfg.space_center) - DW'(cfg.window_tolerance);
    space_hi = DW'(cfg.space_center) + DW'(cfg.window_tolerance);
  end

  // mark has priority over space
  always_comb begin
    cls.is_mark  = (diff > mark_lo) && (diff < mark_hi);
    cls.is_space = !cls.is_mark && (diff > space_lo) && (diff < space_hi);
    cls.period   = diff[fsk_ptd_pkg::VAL_W-1:0];
  end

endmodule

// ===== sim/fsk_period_tone_detector_test.sv =====
`timescale 1ns / 100ps

module fsk_period_tone_detector_test;
  import fsk_ptd_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CAP_W-1:0] cap;
  } capture_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] freq;
    logic [VAL_W-1:0] half_period;
    logic             ready;
  } tone_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;      // capture_value[15:0]
  logic [OP_W-1:0] in_tuser = '0;  // operation[1:0]
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;          // frequency[15:0], half_period[31:16]
  logic out_tuser;                 // ready_res
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0] cfg_wdata = '0;

  fsk_period_tone_detector u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // stimulus and expected results
  capture_item_t pending_edges[$];
  tone_result_t  tone_reports[$];
  capture_item_t drive_item;
  tone_result_t  want;
  bit            no_idle = 1'b0;
  int            mismatches = 0;
  int            cycles = 0;
  logic [CAP_W-1:0] gen_last = '0;

  // detector mirror: settings and state
  cfg_t             tone_cfg;
  bit               seen_edge = 1'b0;
  logic [CAP_W-1:0] prev_cap = '0;
  logic [CNT_W-1:0] mark_run = '0;
  logic [CNT_W-1:0] space_run = '0;
  bit               fresh = 1'b0;
  logic [VAL_W-1:0] pub_freq = '0;
  logic [VAL_W-1:0] pub_period = '0;

  // one accepted item: update the mirror and queue what the block reports
  task automatic classify_edge(input logic [OP_W-1:0] op, input logic [CAP_W-1:0] cap);
    int d;
    int tol;
    int mc;
    int sc;
    tone_result_t res;
    tol = int'(tone_cfg.window_tolerance);
    mc = int'(tone_cfg.mark_center);
    sc = int'(tone_cfg.space_center);
    if (op == OP_CAPTURE) begin
      if (!seen_edge) begin
        seen_edge = 1'b1;
        prev_cap = cap;
      end else begin
        d = int'(cap) - int'(prev_cap);
        // timer wrapped between the previous capture and this one
        if (cap < prev_cap) d += int'(tone_cfg.wrap_amount);
        prev_cap = cap;
        if (d > mc - tol && d < mc + tol) begin
          if (mark_run == '0) begin
            fresh = 1'b1;
            pub_freq = tone_cfg.mark_frequency;
            pub_period = d[15:0];
          end
          mark_run = mark_run + 1'b1;
          space_run = '0;
          if (mark_run == tone_cfg.mark_count_limit) mark_run = '0;
        end else if (d > sc - tol && d < sc + tol) begin
          if (space_run == '0) begin
            fresh = 1'b1;
            pub_freq = tone_cfg.space_frequency;
            pub_period = d[15:0];
          end
          space_run = space_run + 1'b1;
          mark_run = '0;
          if (space_run == tone_cfg.space_count_limit) space_run = '0;
        end
      end
    end else if (op == OP_READ) begin
      fresh = 1'b0;
    end
    res.freq = pub_freq;
    res.half_period = pub_period;
    res.ready = fresh;
    tone_reports.push_back(res);
  endtask

  task automatic queue_op(input logic [OP_W-1:0] op, input logic [CAP_W-1:0] cap);
    capture_item_t it;
    it.op = op;
    it.cap = cap;
    if (op == OP_CAPTURE) gen_last = cap;
    pending_edges.push_back(it);
  endtask

  // next capture a given number of ticks after the previous one
  task automatic queue_capture(input int delta);
    queue_op(OP_CAPTURE, 16'(int'(gen_last) + delta));
  endtask

  // mostly runs of in-window half-periods, with reads and noise mixed in
  task automatic queue_tone_traffic(input int n);
    int left;
    int pick;
    int ctr;
    int tol;
    int off;
    int run;
    left = n;
    tol = int'(tone_cfg.window_tolerance);
    while (left > 0) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        queue_op(OP_READ, 16'($urandom));
      end else if (pick < 11) begin
        queue_op(OP_OVERFLOW, 16'($urandom));
      end else if (pick < 13) begin
        queue_op(OP_SPARE, 16'($urandom));
      end else if (pick < 17) begin
        queue_op(OP_CAPTURE, 16'($urandom));
      end else begin
        ctr = $urandom_range(1) ? int'(tone_cfg.mark_center) : int'(tone_cfg.space_center);
        run = $urandom_range(1, 10);
        repeat (run) begin
          off = int'($urandom_range(0, 2 * tol)) - tol;
          queue_capture(ctr + off);
          if ($urandom_range(9) == 0) queue_op(OP_READ, 16'($urandom));
        end
        left -= run - 1;
      end
      left--;
    end
  endtask

  task automatic program_reg(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_MARK_CENTER:  tone_cfg.mark_center = value;
      REG_SPACE_CENTER: tone_cfg.space_center = value;
      REG_TOLERANCE:    tone_cfg.window_tolerance = value;
      REG_MARK_LIMIT:   tone_cfg.mark_count_limit = value[CNT_W-1:0];
      REG_SPACE_LIMIT:  tone_cfg.space_count_limit = value[CNT_W-1:0];
      REG_WRAP:         tone_cfg.wrap_amount = value;
      REG_MARK_FREQ:    tone_cfg.mark_frequency = value;
      REG_SPACE_FREQ:   tone_cfg.space_frequency = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_settings(input logic [VAL_W-1:0] mc, input logic [VAL_W-1:0] sc,
                               input logic [VAL_W-1:0] tol, input logic [VAL_W-1:0] ml,
                               input logic [VAL_W-1:0] sl, input logic [VAL_W-1:0] wrap,
                               input logic [VAL_W-1:0] mf, input logic [VAL_W-1:0] sf);
    program_reg(REG_MARK_CENTER, mc);
    program_reg(REG_SPACE_CENTER, sc);
    program_reg(REG_TOLERANCE, tol);
    program_reg(REG_MARK_LIMIT, ml);
    program_reg(REG_SPACE_LIMIT, sl);
    program_reg(REG_WRAP, wrap);
    program_reg(REG_MARK_FREQ, mf);
    program_reg(REG_SPACE_FREQ, sf);
  endtask

  // hold off until every item is in and every result is out
  task automatic drain_results();
    do @(negedge clk);
    while (pending_edges.size() != 0 || in_tvalid || tone_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender: hold each item until taken, random gaps between items unless no_idle is set
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) classify_edge(in_tuser, in_tdata);
      if (!in_tvalid || in_tready) begin
        if (pending_edges.size() != 0 && (no_idle || $urandom_range(99) >= 14)) begin
          drive_item = pending_edges.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= drive_item.cap;
          in_tuser <= drive_item.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls unless no_idle is set, compare each result item with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (tone_reports.size() == 0) begin
          $error("result item arrived with nothing expected");
          mismatches++;
        end else begin
          want = tone_reports.pop_front();
          if (out_tdata[15:0] !== want.freq) begin
            $error("frequency: expected %0d, actual %0d", want.freq, out_tdata[15:0]);
            mismatches++;
          end
          if (out_tdata[31:16] !== want.half_period) begin
            $error("half_period: expected %0d, actual %0d", want.half_period,
                   out_tdata[31:16]);
            mismatches++;
          end
          if (out_tuser !== want.ready) begin
            $error("ready_res: expected %0d, actual %0d", want.ready, out_tuser);
            mismatches++;
          end
        end
      end
      out_tready <= no_idle || ($urandom_range(99) >= 14);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    tone_cfg = '{RST_MARK_CENTER, RST_SPACE_CENTER, RST_TOLERANCE, RST_MARK_LIMIT,
                 RST_SPACE_LIMIT, RST_WRAP, RST_MARK_FREQ, RST_SPACE_FREQ};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset settings: idle ops, wrap, strict window edges, count wrap
    queue_op(OP_READ, 16'hFFFF);
    queue_op(OP_OVERFLOW, 16'h0000);
    queue_op(OP_SPARE, 16'hFFFF);
    queue_op(OP_CAPTURE, 16'hFFFF);
    queue_capture(650);
    queue_capture(650);
    queue_capture(550);
    queue_capture(750);
    queue_capture(551);
    queue_op(OP_READ, 16'h0000);
    queue_capture(749);
    queue_capture(325);
    queue_capture(226);
    queue_capture(424);
    queue_capture(225);
    queue_capture(425);
    queue_capture(325);
    queue_capture(325);
    queue_op(OP_OVERFLOW, 16'h5A5A);
    queue_op(OP_SPARE, 16'hA5A5);
    queue_capture(0);
    queue_op(OP_CAPTURE, 16'h0000);
    queue_op(OP_READ, 16'h0000);
    drain_results();

    load_settings(16'd1000, 16'd400, 16'd150, 16'd3, 16'd5, 16'hFFFF, 16'hFFFF, 16'd0);
    queue_tone_traffic(150);
    drain_results();

    // extremes: widest window, zero wrap amount gives negative half-periods
    load_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'd15, 16'd1, 16'd0, 16'hFFFF, 16'd1);
    queue_op(OP_CAPTURE, 16'h0000);
    queue_op(OP_CAPTURE, 16'hFFFF);
    queue_op(OP_CAPTURE, 16'h0000);
    queue_op(OP_CAPTURE, 16'h8000);
    queue_tone_traffic(80);
    drain_results();

    // zero tolerance: strict bounds leave nothing in either window
    program_reg(REG_TOLERANCE, 16'd0);
    queue_tone_traffic(30);
    drain_results();

    // counts run to 15 with a zero limit; short wrap; no stalls on either side
    no_idle = 1'b1;
    load_settings(16'd300, 16'd150, 16'd60, 16'd0, 16'd0, 16'd100, 16'h8001, 16'h7FFE);
    queue_tone_traffic(200);
    drain_results();
    no_idle = 1'b0;

    repeat (4) begin
      load_settings(16'($urandom_range(40, 3000)), 16'($urandom_range(20, 1500)),
                    16'($urandom_range(1, 300)), 16'($urandom_range(1, 15)),
                    16'($urandom_range(1, 15)),
                    ($urandom_range(3) == 0) ? 16'($urandom) : 16'hFFFF,
                    16'($urandom), 16'($urandom));
      queue_tone_traffic(80);
      drain_results();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== fsk_period_tone_detector.f =====
+incdir+hdl
hdl/fsk_ptd_pkg.sv
hdl/fsk_ptd_cfg.sv
hdl/fsk_ptd_classify.sv
hdl/fsk_period_tone_detector.sv
sim/fsk_period_tone_detector_test.sv
